// ===== rtl/core/lift_status_burst_transmitter_defines.svh =====
// Assertion helpers used by the transmitter RTL.
`ifndef LIFT_STATUS_BURST_TRANSMITTER_DEFINES_SVH
`define LIFT_STATUS_BURST_TRANSMITTER_DEFINES_SVH

// Same-cycle implication.
`define LSBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LSBT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lsbt_pkg.sv =====
package lsbt_pkg;

   localparam int unsigned FLOORS      = 18;
   localparam int unsigned PIN_W       = 18;
   localparam int unsigned FLOOR_W     = 5;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned CNT_W       = 32;
   localparam int unsigned GAP_W       = 16;
   localparam int unsigned BLEN_W      = 4;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [MODE_W-1:0] MODE_LEGACY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CRC    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd2;

   localparam logic [GAP_W-1:0]  RST_BURST_GAP = 16'd10;
   localparam logic [GAP_W-1:0]  RST_HEARTBEAT = 16'd2000;
   localparam logic [BLEN_W-1:0] RST_BURST_LEN = 4'd3;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;

   localparam logic [2:0] SVC_ALL_PINS = 3'd1;
   localparam logic [2:0] SVC_REVISION = 3'd2;
   localparam logic [2:0] SVC_RELAY    = 3'd3;
   localparam logic [2:0] SVC_NORMAL   = 3'd5;

   localparam logic KIND_LEGACY = 1'b0;
   localparam logic KIND_CRC    = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_MODE,
      CSR_BURST_GAP,
      CSR_HEARTBEAT,
      CSR_BURST_LENGTH
   } lsbt_csr_index_type;

   typedef struct packed {
      logic [MODE_W-1:0] frame_mode;
      logic [GAP_W-1:0]  repeat_gap;
      logic [GAP_W-1:0]  idle_period;
      logic [BLEN_W-1:0] burst_length;
   } lsbt_cfg_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] floor;
      logic [FLOOR_W-1:0] destination;
      logic               occupied;
      logic [1:0]         direction;
      logic [2:0]         service;
      logic               legacy_en;
      logic               crc_en;
      logic [CNT_W-1:0]   frames_total;
      logic [CNT_W-1:0]   bursts_total;
   } lsbt_job_type;

endpackage

// ===== rtl/core/lsbt_front.sv =====
module lsbt_front (
   input  logic                        clock,
   input  logic                        reset,
   input  lsbt_pkg::lsbt_cfg_type      cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lsbt_pkg::PIN_W-1:0]  req_position_pins,
   input  logic [lsbt_pkg::PIN_W-1:0]  req_stop_pins,
   input  logic                        req_up_level,
   input  logic                        req_down_level,
   input  logic                        req_occupied_level,
   input  logic                        req_revision_level,
   input  logic                        req_relay_level,
   input  logic [lsbt_pkg::TIME_W-1:0] req_time_ms,
   input  logic                        q_full,
   output logic                        push_valid,
   output lsbt_pkg::lsbt_job_type      push_job
);
   import lsbt_pkg::*;

   function automatic logic [FLOOR_W-1:0] top_index(logic [FLOORS-1:0] v);
      logic [FLOOR_W-1:0] r;
      r = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (v[i]) begin
            r = FLOOR_W'(i);
         end
      end
      return r;
   endfunction

   logic [FLOORS-1:0]  pos_low, stop_low;
   logic               pos_one;
   logic [FLOOR_W-1:0] held_floor_in, held_dest_in;
   logic [1:0]         dir_in;
   logic [2:0]         svc_in;
   logic               accept;

   logic               s1_valid_ff;
   logic               s1_occ_ff;
   logic [1:0]         s1_dir_ff;
   logic [2:0]         s1_svc_ff;
   logic [TIME_W-1:0]  s1_time_ff;
   logic [FLOOR_W-1:0] held_floor_ff, held_dest_ff;

   logic [FLOOR_W-1:0] sent_floor_ff, sent_dest_ff;
   logic               sent_occ_ff;
   logic [1:0]         sent_dir_ff;
   logic [2:0]         sent_svc_ff;
   logic [BLEN_W-1:0]  repeats_ff;
   logic [TIME_W-1:0]  last_rep_ff, last_send_ff;
   logic [CNT_W-1:0]   frame_cnt_ff, tx_cnt_ff;

   logic               changed, rep_nz, gap_ok, hb_ok, do_tx, s2_go;
   logic               legacy_en, crc_en;
   logic [TIME_W-1:0]  since_rep, since_send;
   logic [CNT_W-1:0]   frame_cnt_in, tx_cnt_in;

   // classify
   always_comb begin
      pos_low  = ~FLOORS'(req_position_pins);
      stop_low = ~FLOORS'(req_stop_pins);
      pos_one  = (pos_low != '0) && ((pos_low & (pos_low - FLOORS'(1))) == '0);
      held_floor_in = pos_one ? top_index(pos_low) : held_floor_ff;
      held_dest_in  = (stop_low != '0) ? top_index(stop_low) : held_dest_ff;
      if (req_up_level && !req_down_level) begin
         dir_in = DIR_UP;
      end else if (!req_up_level && req_down_level) begin
         dir_in = DIR_DOWN;
      end else begin
         dir_in = DIR_NONE;
      end
      if ((&pos_low) && (stop_low == '0)) begin
         svc_in = SVC_ALL_PINS;
      end else if (!req_revision_level) begin
         svc_in = SVC_REVISION;
      end else if (!req_relay_level) begin
         svc_in = SVC_RELAY;
      end else begin
         svc_in = SVC_NORMAL;
      end
   end

   // decide
   always_comb begin
      changed = (held_floor_ff != sent_floor_ff) || (held_dest_ff != sent_dest_ff) ||
                (s1_occ_ff != sent_occ_ff) || (s1_dir_ff != sent_dir_ff) ||
                (s1_svc_ff != sent_svc_ff);
      since_rep  = s1_time_ff - last_rep_ff;
      since_send = s1_time_ff - last_send_ff;
      gap_ok = since_rep >= TIME_W'(cfg.repeat_gap);
      hb_ok  = since_send >= TIME_W'(cfg.idle_period);
      rep_nz = repeats_ff != '0;
      do_tx  = changed || (rep_nz && gap_ok) || (!rep_nz && hb_ok);
      s2_go  = s1_valid_ff && (!do_tx || !q_full);
      legacy_en = cfg.frame_mode != MODE_CRC;
      crc_en    = cfg.frame_mode != MODE_LEGACY;
      tx_cnt_in    = tx_cnt_ff + CNT_W'(1);
      frame_cnt_in = frame_cnt_ff + CNT_W'(legacy_en) + CNT_W'(crc_en);
   end

   assign req_ready  = !s1_valid_ff || s2_go;
   assign accept     = req_valid && req_ready;
   assign push_valid = s2_go && do_tx;

   always_comb begin
      push_job.floor        = held_floor_ff;
      push_job.destination  = held_dest_ff;
      push_job.occupied     = s1_occ_ff;
      push_job.direction    = s1_dir_ff;
      push_job.service      = s1_svc_ff;
      push_job.legacy_en    = legacy_en;
      push_job.crc_en       = crc_en;
      push_job.frames_total = frame_cnt_in;
      push_job.bursts_total = tx_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_occ_ff  <= ~req_occupied_level;
         s1_dir_ff  <= dir_in;
         s1_svc_ff  <= svc_in;
         s1_time_ff <= req_time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         held_floor_ff <= '0;
         held_dest_ff  <= '0;
         sent_floor_ff <= '0;
         sent_dest_ff  <= '0;
         sent_occ_ff   <= 1'b0;
         sent_dir_ff   <= '0;
         sent_svc_ff   <= '0;
         repeats_ff    <= '0;
         last_rep_ff   <= '0;
         last_send_ff  <= '0;
         frame_cnt_ff  <= '0;
         tx_cnt_ff     <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff   <= 1'b1;
            held_floor_ff <= held_floor_in;
            held_dest_ff  <= held_dest_in;
         end else if (s2_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (push_valid) begin
            frame_cnt_ff <= frame_cnt_in;
            tx_cnt_ff    <= tx_cnt_in;
            last_send_ff <= s1_time_ff;
            if (changed) begin
               sent_floor_ff <= held_floor_ff;
               sent_dest_ff  <= held_dest_ff;
               sent_occ_ff   <= s1_occ_ff;
               sent_dir_ff   <= s1_dir_ff;
               sent_svc_ff   <= s1_svc_ff;
               repeats_ff    <= (cfg.burst_length != '0) ?
                                cfg.burst_length - BLEN_W'(1) : '0;
               last_rep_ff   <= s1_time_ff;
            end else if (rep_nz) begin
               repeats_ff  <= repeats_ff - BLEN_W'(1);
               last_rep_ff <= s1_time_ff;
            end
         end
      end
   end

endmodule

// ===== rtl/core/lsbt_queue.sv =====
module lsbt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  lsbt_pkg::lsbt_job_type push_job,
   output logic                   q_full,
   output logic                   q_valid,
   output lsbt_pkg::lsbt_job_type q_job,
   input  logic                   q_pop
);
   import lsbt_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

   lsbt_job_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_QW-1:0]  count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign q_full  = count_ff == CNT_QW'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (q_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         count_ff <= count_ff + CNT_QW'(push_valid) - CNT_QW'(q_pop);
      end
   end

endmodule

// ===== rtl/core/lsbt_back.sv =====
`include "lift_status_burst_transmitter_defines.svh"

module lsbt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  lsbt_pkg::lsbt_job_type     q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_frame_kind,
   output logic                       rsp_last_byte,
   output logic [lsbt_pkg::CNT_W-1:0] rsp_frames_total,
   output logic [lsbt_pkg::CNT_W-1:0] rsp_bursts_total
);
   import lsbt_pkg::*;

   localparam logic [4:0] IDX_OPEN      = 5'd0;
   localparam logic [4:0] IDX_PAY_FIRST = 5'd1;
   localparam logic [4:0] IDX_PAY_LAST  = 5'd11;
   localparam logic [4:0] IDX_SEP       = 5'd12;
   localparam logic [4:0] IDX_HEX_HI    = 5'd13;
   localparam logic [4:0] IDX_HEX_LO    = 5'd14;
   localparam logic [4:0] IDX_BRACE     = 5'd15;
   localparam logic [4:0] IDX_CRC_CR    = 5'd16;
   localparam logic [4:0] IDX_CRC_LF    = 5'd17;
   localparam logic [4:0] IDX_LEG_LF    = 5'd14;

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CRC_POLY  = 8'h07;

   function automatic logic [7:0] tens_char(logic [FLOOR_W-1:0] v);
      logic [7:0] t;
      if (v >= FLOOR_W'(30)) t = 8'd3;
      else if (v >= FLOOR_W'(20)) t = 8'd2;
      else if (v >= FLOOR_W'(10)) t = 8'd1;
      else t = 8'd0;
      return CH_ZERO + t;
   endfunction

   function automatic logic [7:0] ones_char(logic [FLOOR_W-1:0] v);
      logic [7:0] w;
      w = 8'(v);
      if (w >= 8'd30) w = w - 8'd30;
      else if (w >= 8'd20) w = w - 8'd20;
      else if (w >= 8'd10) w = w - 8'd10;
      return CH_ZERO + w;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_A + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] crc8(logic [7:0] c, logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [7:0] frame_byte(lsbt_job_type j, logic kind,
                                             logic [4:0] idx, logic [7:0] crc);
      logic [7:0] b;
      case (idx)
         IDX_OPEN:   b = (kind == KIND_CRC) ? CH_LBRACE : CH_LT;
         5'd1:       b = tens_char(j.floor);
         5'd2:       b = ones_char(j.floor);
         5'd3:       b = CH_COMMA;
         5'd4:       b = tens_char(j.destination);
         5'd5:       b = ones_char(j.destination);
         5'd6:       b = CH_COMMA;
         5'd7:       b = CH_ZERO + 8'(j.occupied);
         5'd8:       b = CH_COMMA;
         5'd9:       b = CH_ZERO + 8'(j.direction);
         5'd10:      b = CH_COMMA;
         5'd11:      b = CH_ZERO + 8'(j.service);
         IDX_SEP:    b = (kind == KIND_CRC) ? CH_COMMA : CH_GT;
         IDX_HEX_HI: b = (kind == KIND_CRC) ? hex_char(crc[7:4]) : CH_CR;
         IDX_HEX_LO: b = (kind == KIND_CRC) ? hex_char(crc[3:0]) : CH_LF;
         IDX_BRACE:  b = CH_RBRACE;
         IDX_CRC_CR: b = CH_CR;
         IDX_CRC_LF: b = CH_LF;
         default:    b = '0;
      endcase
      return b;
   endfunction

   lsbt_job_type     job_ff;
   logic             act_ff;
   logic             kind_ff;
   logic [4:0]       idx_ff;
   logic [7:0]       crc_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_kind_ff;
   logic             rsp_last_ff;
   logic [CNT_W-1:0] rsp_frames_ff, rsp_bursts_ff;

   logic             advance, frame_end, out_last, crc_take;
   logic [7:0]       cur_byte;

   always_comb begin
      advance   = act_ff && (!rsp_valid_ff || rsp_ready);
      cur_byte  = frame_byte(job_ff, kind_ff, idx_ff, crc_ff);
      frame_end = (kind_ff == KIND_CRC) ? (idx_ff == IDX_CRC_LF) : (idx_ff == IDX_LEG_LF);
      out_last  = frame_end && ((kind_ff == KIND_CRC) || !job_ff.crc_en);
      crc_take  = (kind_ff == KIND_CRC) && (idx_ff >= IDX_PAY_FIRST) &&
                  (idx_ff <= IDX_PAY_LAST);
      q_pop     = q_valid && (!act_ff || (advance && out_last));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            act_ff <= 1'b1;
         end else if (advance && out_last) begin
            act_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff  <= q_job;
         kind_ff <= q_job.legacy_en ? KIND_LEGACY : KIND_CRC;
         idx_ff  <= '0;
         crc_ff  <= '0;
      end else if (advance) begin
         if (frame_end) begin
            kind_ff <= KIND_CRC;
            idx_ff  <= '0;
            crc_ff  <= '0;
         end else begin
            idx_ff <= idx_ff + 5'd1;
            if (crc_take) begin
               crc_ff <= crc8(crc_ff, cur_byte);
            end
         end
      end
      if (advance) begin
         rsp_byte_ff   <= cur_byte;
         rsp_kind_ff   <= kind_ff;
         rsp_last_ff   <= out_last;
         rsp_frames_ff <= job_ff.frames_total;
         rsp_bursts_ff <= job_ff.bursts_total;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_byte      = rsp_byte_ff;
   assign rsp_frame_kind   = rsp_kind_ff;
   assign rsp_last_byte    = rsp_last_ff;
   assign rsp_frames_total = rsp_frames_ff;
   assign rsp_bursts_total = rsp_bursts_ff;

   `LSBT_ASSERT_IMP(a_legacy_enabled, clock, reset, act_ff && (kind_ff == KIND_LEGACY), job_ff.legacy_en, "legacy frame sent while disabled")
   `LSBT_ASSERT_IMP(a_some_frame, clock, reset, act_ff, job_ff.legacy_en || job_ff.crc_en, "transaction with no frame")
   `LSBT_ASSERT_IMP(a_idx_range, clock, reset, act_ff, (idx_ff <= IDX_CRC_LF) && ((kind_ff == KIND_CRC) || (idx_ff <= IDX_LEG_LF)), "byte index past frame end")
   `LSBT_ASSERT_NEXT(a_drain, clock, reset, advance && out_last && !q_valid, !act_ff, "serializer busy after last byte")

endmodule

// ===== rtl/core/lift_status_burst_transmitter.sv =====
// Lift status burst transmitter.
// req_* carries one timed pin sample per transaction (valid/ready). Each
// sample updates the held floor and destination and may start a
// transmission: on a status change, on a burst repeat, or on a heartbeat.
// rsp_* carries the transmitted ASCII text one byte per transaction, with
// the frame kind, a last-byte flag and the frame and transmission counts.
// csr_* writes the four registers at any edge with csr_write_enable high.
// An accepted sample is registered in the decision stage and queued; the
// serializer pops it when free and registers its bytes onto rsp_*. A
// sample is taken every cycle; a transmission of 15, 18 or 33 bytes holds
// the serializer (one byte per cycle), and up to 4 pending transmissions
// queue between the decision stage and the serializer. Samples stall only
// when that queue is full and the next sample also needs a transmission.
// Reset clears all status, counters and the queue and loads the register
// defaults (both frames, gap 10 ms, heartbeat 2000 ms, burst of 3).
// When the receiver holds rsp_ready low the current byte holds and the
// queue fills; input samples keep flowing until it is full.
module lift_status_burst_transmitter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lsbt_pkg::PIN_W-1:0]       req_position_pins,
   input  logic [lsbt_pkg::PIN_W-1:0]       req_stop_pins,
   input  logic                             req_up_level,
   input  logic                             req_down_level,
   input  logic                             req_occupied_level,
   input  logic                             req_revision_level,
   input  logic                             req_relay_level,
   input  logic [lsbt_pkg::TIME_W-1:0]      req_time_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_frame_kind,
   output logic                             rsp_last_byte,
   output logic [lsbt_pkg::CNT_W-1:0]       rsp_frames_total,
   output logic [lsbt_pkg::CNT_W-1:0]       rsp_bursts_total,
   input  logic                             csr_write_enable,
   input  logic [lsbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsbt_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import lsbt_pkg::*;

   lsbt_cfg_type cfg_ff;
   logic         push_valid, q_full, q_valid, q_pop;
   lsbt_job_type push_job, q_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode   <= MODE_BOTH;
         cfg_ff.repeat_gap   <= RST_BURST_GAP;
         cfg_ff.idle_period  <= RST_HEARTBEAT;
         cfg_ff.burst_length <= RST_BURST_LEN;
      end else if (csr_write_enable) begin
         case (lsbt_csr_index_type'(csr_index))
            CSR_FRAME_MODE:   cfg_ff.frame_mode   <= csr_write_data[MODE_W-1:0];
            CSR_BURST_GAP:    cfg_ff.repeat_gap   <= csr_write_data[GAP_W-1:0];
            CSR_HEARTBEAT:    cfg_ff.idle_period  <= csr_write_data[GAP_W-1:0];
            CSR_BURST_LENGTH: cfg_ff.burst_length <= csr_write_data[BLEN_W-1:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   lsbt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_position_pins  (req_position_pins),
      .req_stop_pins      (req_stop_pins),
      .req_up_level       (req_up_level),
      .req_down_level     (req_down_level),
      .req_occupied_level (req_occupied_level),
      .req_revision_level (req_revision_level),
      .req_relay_level    (req_relay_level),
      .req_time_ms        (req_time_ms),
      .q_full             (q_full),
      .push_valid         (push_valid),
      .push_job           (push_job)
   );

   lsbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .q_pop      (q_pop)
   );

   lsbt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_job            (q_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_frames_total (rsp_frames_total),
      .rsp_bursts_total (rsp_bursts_total)
   );

endmodule
